@@ src/assert_macros.svh @@
// Assertion macros used by the checker of the duty meter.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ src/pcdm_pkg.sv @@
// Package for the PWM capture duty meter: widths, word types and FSM codes.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package pcdm_pkg;

  // Width of the free-running capture timer; lengths wrap at this width.
  localparam int COUNT_WIDTH = 32;
  // The sum of two lengths needs one bit more so that it cannot wrap.
  localparam int SUM_WIDTH   = COUNT_WIDTH + 1;
  // Widths of the result fields.
  localparam int TICK_WIDTH  = 32;
  localparam int DUTY_WIDTH  = 7;

  // Scale of the duty figure and the number of its bits walked by the divider.
  localparam int DIV_STEPS   = 8;
  localparam int IDX_WIDTH   = $clog2(DIV_STEPS);
  localparam logic [DIV_STEPS-1:0] PCT_SCALE = DIV_STEPS'(100);
  localparam int QUOT_WIDTH  = DIV_STEPS;

  typedef struct packed {
    logic [31:0] capture_time;
    logic        pin_level;
  } cap_word_t;

  typedef struct packed {
    logic [TICK_WIDTH-1:0] high_ticks;
    logic [TICK_WIDTH-1:0] low_ticks;
    logic [DUTY_WIDTH-1:0] duty_percent;
    logic                  duty_valid;
  } res_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DBL,
    ST_ADD,
    ST_DONE,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // take the edge word, update stamps and lengths
    logic start;     // form the period sum and clear the divider
    logic step_dbl;  // doubling half of one divider bit
    logic step_add;  // add half of one divider bit (bit of the scale set)
    logic finish;    // load the result register
  } dp_cmd_t;

  // Cuts or zero-extends a timer value to the counter width.
  function automatic logic [COUNT_WIDTH-1:0] fit_count(input logic [31:0] t);
    logic [COUNT_WIDTH+31:0] w;
    w = {{COUNT_WIDTH{1'b0}}, t};
    return w[COUNT_WIDTH-1:0];
  endfunction

  // Low bits of a length as shown in the result word.
  function automatic logic [TICK_WIDTH-1:0] fit_ticks(input logic [COUNT_WIDTH-1:0] v);
    logic [COUNT_WIDTH+TICK_WIDTH-1:0] w;
    w = {{TICK_WIDTH{1'b0}}, v};
    return w[TICK_WIDTH-1:0];
  endfunction

endpackage

@@ src/pcdm_datapath.sv @@
// Datapath of the duty meter: edge stamps, pulse lengths and a bit-serial divider.
// Depends on pcdm_pkg; driven by commands from pcdm_ctrl.
`timescale 1ns / 1ps

module pcdm_datapath (
  input  logic                clk,
  input  logic                rst,
  input  pcdm_pkg::dp_cmd_t   cmd,
  input  pcdm_pkg::cap_word_t cap_word,
  output pcdm_pkg::res_word_t res_word
);
  import pcdm_pkg::*;

  logic [COUNT_WIDTH-1:0] rise_stamp;
  logic [COUNT_WIDTH-1:0] fall_stamp;
  logic [COUNT_WIDTH-1:0] high_len;
  logic [COUNT_WIDTH-1:0] low_len;
  logic [SUM_WIDTH-1:0]   sum;
  logic [SUM_WIDTH-1:0]   rem;
  logic [QUOT_WIDTH-1:0]  quot;

  logic [COUNT_WIDTH-1:0] t_now;
  logic [SUM_WIDTH-1:0]   dbl_gap;
  logic [SUM_WIDTH-1:0]   high_ext;
  logic [SUM_WIDTH-1:0]   low_ext;
  logic                   dbl_ge;
  logic                   add_ge;

  assign t_now    = fit_count(cap_word.capture_time);
  assign high_ext = {1'b0, high_len};
  assign low_ext  = {1'b0, low_len};
  // The remainder stays below the sum, so sum - rem is positive.
  assign dbl_gap  = sum - rem;
  assign dbl_ge   = (rem >= dbl_gap);
  // sum - high equals the low length.
  assign add_ge   = (rem >= low_ext);

  // Edge state, reset to zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      rise_stamp <= '0;
      fall_stamp <= '0;
      high_len   <= '0;
      low_len    <= '0;
    end else if (cmd.capture) begin
      if (cap_word.pin_level) begin
        rise_stamp <= t_now;
        low_len    <= t_now - fall_stamp;
      end else begin
        fall_stamp <= t_now;
        high_len   <= t_now - rise_stamp;
      end
    end
  end

  // Divider: rem and quot track high * m = quot * sum + rem as m walks the scale.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sum  <= high_ext + low_ext;
      rem  <= '0;
      quot <= '0;
    end else if (cmd.step_dbl) begin
      quot <= {quot[QUOT_WIDTH-2:0], dbl_ge};
      if (dbl_ge) begin
        rem <= rem - dbl_gap;
      end else begin
        rem <= {rem[SUM_WIDTH-2:0], 1'b0};
      end
    end else if (cmd.step_add) begin
      quot <= quot + QUOT_WIDTH'(add_ge);
      if (add_ge) begin
        rem <= rem - low_ext;
      end else begin
        rem <= rem + high_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_word.high_ticks   <= fit_ticks(high_len);
      res_word.low_ticks    <= fit_ticks(low_len);
      res_word.duty_valid   <= (sum != '0);
      res_word.duty_percent <= (sum != '0) ? quot[DUTY_WIDTH-1:0] : '0;
    end
  end

endmodule

@@ src/pcdm_ctrl.sv @@
// Controller of the duty meter: handshakes and sequencing of the divider steps.
// Depends on pcdm_pkg; commands pcdm_datapath.
`timescale 1ns / 1ps

module pcdm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cap_valid,
  output logic              cap_stall,
  output logic              res_valid,
  input  logic              res_stall,
  output pcdm_pkg::dp_cmd_t cmd
);
  import pcdm_pkg::*;

  state_t                state;
  state_t                state_next;
  logic [IDX_WIDTH-1:0]  bit_idx;
  logic [IDX_WIDTH-1:0]  bit_idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      bit_idx <= '0;
    end else begin
      state   <= state_next;
      bit_idx <= bit_idx_next;
    end
  end

  always_comb begin
    state_next   = state;
    bit_idx_next = bit_idx;
    cmd          = '0;
    cap_stall    = 1'b1;
    res_valid    = 1'b0;
    case (state)
      ST_IDLE: begin
        cap_stall = 1'b0;
        if (cap_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.start    = 1'b1;
        bit_idx_next = IDX_WIDTH'(DIV_STEPS - 1);
        state_next   = ST_DBL;
      end
      ST_DBL: begin
        cmd.step_dbl = 1'b1;
        state_next   = ST_ADD;
      end
      ST_ADD: begin
        cmd.step_add = PCT_SCALE[bit_idx];
        if (bit_idx == '0) begin
          state_next = ST_DONE;
        end else begin
          bit_idx_next = bit_idx - 1'b1;
          state_next   = ST_DBL;
        end
      end
      ST_DONE: begin
        cmd.finish = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        res_valid = 1'b1;
        if (!res_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ src/pwm_capture_duty_meter_core.sv @@
// PWM capture duty meter: one result word per capture word (one signal edge).
// A capture word is taken in idle; the sum, the bit-serial divider (a doubling
// and an add step for each of the 8 bits of the scale) and the result register
// follow, and no new capture word is taken until the result word is taken.
// Reset (rst, synchronous): stamps and lengths clear to zero, controller idles.
`timescale 1ns / 1ps

module pwm_capture_duty_meter_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                cap_valid,
  output logic                cap_stall,
  input  pcdm_pkg::cap_word_t cap_word,
  output logic                res_valid,
  input  logic                res_stall,
  output pcdm_pkg::res_word_t res_word
);
  import pcdm_pkg::*;

  // The controller walks one word at a time through capture, sum, the
  // divider steps and the result register. While a word is in flight the
  // capture side is stalled, so the stamps never change under the divider.
  dp_cmd_t cmd;

  pcdm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cap_valid (cap_valid),
    .cap_stall (cap_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .cmd       (cmd)
  );

  // The datapath keeps the edge stamps and pulse lengths, and works out the
  // duty as floor(high * 100 / (high + low)) without a wide multiplier:
  // for each bit of 100 it doubles the running remainder and, where the bit
  // is set, adds the high length, reducing modulo the widened sum each time.
  // A zero sum gives a duty of zero, flagged invalid.
  pcdm_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cap_word (cap_word),
    .res_word (res_word)
  );

endmodule

@@ src/pcdm_checker.sv @@
// Port-level checker for the duty meter, bound to the top level.
// Depends on pcdm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pcdm_checker (
  input logic                clk,
  input logic                rst,
  input logic                cap_valid,
  input logic                cap_stall,
  input pcdm_pkg::cap_word_t cap_word,
  input logic                res_valid,
  input logic                res_stall,
  input pcdm_pkg::res_word_t res_word
);
  import pcdm_pkg::*;

  // A stalled result word holds.
  `ASSERT_NEXT(a_res_hold, clk, rst, res_valid && res_stall, res_valid && $stable(res_word))
  // A taken capture word closes the capture side in the next cycle.
  `ASSERT_NEXT(a_cap_close, clk, rst, cap_valid && !cap_stall, cap_stall)
  // The capture side is never open while a result word waits.
  `ASSERT_IMPLIES(a_one_word, clk, rst, res_valid, cap_stall)
  // An invalid duty reads as zero.
  `ASSERT_IMPLIES(a_zero_duty, clk, rst, res_valid && !res_word.duty_valid, res_word.duty_percent == '0)
  // The duty never exceeds one hundred percent.
  `ASSERT_IMPLIES(a_duty_range, clk, rst, res_valid, res_word.duty_percent <= DUTY_WIDTH'(100))

endmodule

bind pwm_capture_duty_meter_core pcdm_checker u_pcdm_checker (
  .clk       (clk),
  .rst       (rst),
  .cap_valid (cap_valid),
  .cap_stall (cap_stall),
  .cap_word  (cap_word),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_word  (res_word)
);
